[sv/visible_text_line_formatter_core_defines.svh]
// Assertion macros for the text line formatter checker.
// No dependencies.
`ifndef VISIBLE_TEXT_LINE_FORMATTER_CORE_DEFINES_SVH
`define VISIBLE_TEXT_LINE_FORMATTER_CORE_DEFINES_SVH

// same-cycle implication
`define VTLF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VTLF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/vtlf_pkg.sv]
// Shared types and constants of the text line formatter.
// No dependencies.
package vtlf_pkg;

    localparam int NUMBER_DIGITS = 6;
    localparam int FIFO_DEPTH    = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUMBER_MODE      = 3'd0,
        REG_SQUEEZE_BLANK    = 3'd1,
        REG_SHOW_NONPRINTING = 3'd2,
        REG_SHOW_LINE_ENDS   = 3'd3,
        REG_SHOW_TAB_CHARS   = 3'd4
    } reg_idx_t;

    localparam logic [1:0] NUM_OFF = 2'd0;
    localparam logic [1:0] NUM_ALL = 2'd1;

    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_NL       = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_QMARK    = 8'h3F;
    localparam logic [7:0] CH_I        = 8'h49;
    localparam logic [7:0] CH_M        = 8'h4D;
    localparam logic [7:0] CH_CARET    = 8'h5E;
    localparam logic [7:0] CTRL_OFFSET = 8'h40;
    localparam logic [6:0] LOW_DEL     = 7'h7F;
    localparam logic [6:0] LOW_SPACE   = 7'h20;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       squeeze_blank;
        logic       show_nonprinting;
        logic       show_line_ends;
        logic       show_tab_chars;
    } cfg_t;

    // classified item handed from front to back
    typedef struct packed {
        logic       has_num;
        logic       is_nl;
        logic [7:0] data;
    } desc_t;

endpackage

[sv/vtlf_fifo.sv]
// Short register queue between the front and back parts.
// Depends on nothing.
module vtlf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/vtlf_front.sv]
// Front part: accepts input items, tracks line state and the BCD line counter.
// Depends on vtlf_pkg.
module vtlf_front #(
    parameter int NUMBER_DIGITS = vtlf_pkg::NUMBER_DIGITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  vtlf_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   in_data,
    input  logic                         in_new_file,
    input  logic                         fifo_full,
    output logic                         push,
    output vtlf_pkg::desc_t              push_desc,
    output logic [4*NUMBER_DIGITS-1:0]   push_num
);

    localparam int NUM_W = 4 * NUMBER_DIGITS;

    logic             at_line_start_reg, at_line_start_next;
    logic             prev_blank_reg, prev_blank_next;
    logic [NUM_W-1:0] line_num_reg, line_num_next;
    logic             accept;
    logic             als, pb;
    logic [NUM_W-1:0] num;
    logic             has_num;

    function automatic logic [NUM_W-1:0] bcd_inc(input logic [NUM_W-1:0] v);
        logic [NUM_W-1:0] res;
        logic             carry;
        logic             nines;
        logic [4:0]       d;
        res   = '0;
        carry = 1'b1;
        nines = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (v[4*i +: 4] != 4'd9)
            begin
                nines = 1'b0;
            end
        end
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            d = {1'b0, v[4*i +: 4]} + {4'd0, carry};
            if (d > 5'd9)
            begin
                res[4*i +: 4] = 4'd0;
                carry         = 1'b1;
            end
            else
            begin
                res[4*i +: 4] = d[3:0];
                carry         = 1'b0;
            end
        end
        return nines ? v : res;
    endfunction

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;

    assign als = in_new_file ? 1'b1 : at_line_start_reg;
    assign pb  = in_new_file ? 1'b0 : prev_blank_reg;
    assign num = in_new_file ? '0 : line_num_reg;

    always_comb
    begin
        at_line_start_next = at_line_start_reg;
        prev_blank_next    = prev_blank_reg;
        line_num_next      = line_num_reg;
        push               = 1'b0;
        has_num            = 1'b0;
        if (accept)
        begin
            at_line_start_next = als;
            prev_blank_next    = pb;
            line_num_next      = num;
            if (in_data == vtlf_pkg::CH_NL)
            begin
                if (!(als && cfg.squeeze_blank && pb))
                begin
                    if (als)
                    begin
                        prev_blank_next = 1'b1;
                        has_num = (cfg.number_mode == vtlf_pkg::NUM_ALL);
                    end
                    push = 1'b1;
                    at_line_start_next = 1'b1;
                end
            end
            else
            begin
                if (als)
                begin
                    prev_blank_next = 1'b0;
                    has_num = (cfg.number_mode != vtlf_pkg::NUM_OFF);
                end
                at_line_start_next = 1'b0;
                push = 1'b1;
            end
            if (has_num)
            begin
                line_num_next = bcd_inc(num);
            end
        end
    end

    assign push_desc.has_num = has_num;
    assign push_desc.is_nl   = (in_data == vtlf_pkg::CH_NL);
    assign push_desc.data    = in_data;
    assign push_num          = line_num_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_line_start_reg <= 1'b1;
            prev_blank_reg    <= 1'b0;
            line_num_reg      <= '0;
        end
        else
        begin
            at_line_start_reg <= at_line_start_next;
            prev_blank_reg    <= prev_blank_next;
            line_num_reg      <= line_num_next;
        end
    end

endmodule

[sv/vtlf_back.sv]
// Back part: expands each queued item into output bytes, one per cycle while the output is not stalled.
// Depends on vtlf_pkg.
module vtlf_back #(
    parameter int NUMBER_DIGITS = vtlf_pkg::NUMBER_DIGITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  vtlf_pkg::cfg_t               cfg,
    input  logic                         head_valid,
    input  vtlf_pkg::desc_t              head_desc,
    input  logic [4*NUMBER_DIGITS-1:0]   head_num,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   out_byte,
    output logic                         out_last
);

    localparam int IDX_W = $clog2(NUMBER_DIGITS + 5);
    localparam int DIG_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
    localparam logic [IDX_W-1:0] TAB_POS       = IDX_W'(NUMBER_DIGITS);
    localparam logic [IDX_W-1:0] FIRST_CONTENT = IDX_W'(NUMBER_DIGITS + 1);

    logic             started_reg, started_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;

    logic [3:0][7:0]  cbytes;
    logic [2:0]       clen;
    logic [1:0]       base;
    logic [6:0]       low7;
    logic [7:0]       dig_chars [NUMBER_DIGITS];
    logic             lead;
    logic [3:0]       d;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] end_idx;
    logic [IDX_W-1:0] coff;
    logic [7:0]       sel_byte;
    logic             is_last;
    logic             load;

    // content bytes of the item
    always_comb
    begin
        cbytes = '0;
        clen   = 3'd1;
        base   = 2'd0;
        low7   = head_desc.data[6:0];
        if (head_desc.is_nl)
        begin
            if (cfg.show_line_ends)
            begin
                cbytes[0] = vtlf_pkg::CH_DOLLAR;
                cbytes[1] = vtlf_pkg::CH_NL;
                clen      = 3'd2;
            end
            else
            begin
                cbytes[0] = vtlf_pkg::CH_NL;
            end
        end
        else if (head_desc.data == vtlf_pkg::CH_TAB)
        begin
            if (cfg.show_tab_chars)
            begin
                cbytes[0] = vtlf_pkg::CH_CARET;
                cbytes[1] = vtlf_pkg::CH_I;
                clen      = 3'd2;
            end
            else
            begin
                cbytes[0] = vtlf_pkg::CH_TAB;
            end
        end
        else if (!cfg.show_nonprinting)
        begin
            cbytes[0] = head_desc.data;
        end
        else
        begin
            if (head_desc.data[7])
            begin
                cbytes[0] = vtlf_pkg::CH_M;
                cbytes[1] = vtlf_pkg::CH_DASH;
                base      = 2'd2;
            end
            if (low7 < vtlf_pkg::LOW_SPACE)
            begin
                cbytes[base]        = vtlf_pkg::CH_CARET;
                cbytes[base + 2'd1] = {1'b0, low7} + vtlf_pkg::CTRL_OFFSET;
                clen                = {1'b0, base} + 3'd2;
            end
            else if (low7 == vtlf_pkg::LOW_DEL)
            begin
                cbytes[base]        = vtlf_pkg::CH_CARET;
                cbytes[base + 2'd1] = vtlf_pkg::CH_QMARK;
                clen                = {1'b0, base} + 3'd2;
            end
            else
            begin
                cbytes[base] = {1'b0, low7};
                clen         = {1'b0, base} + 3'd1;
            end
        end
    end

    // number digits, most significant first, leading zeros as spaces
    always_comb
    begin
        lead = 1'b1;
        d    = '0;
        for (int j = 0; j < NUMBER_DIGITS; j++)
        begin
            d = head_num[4*(NUMBER_DIGITS-1-j) +: 4];
            if (d > 4'd9)
            begin
                d = 4'd9;
            end
            if (lead && d == 4'd0 && j != NUMBER_DIGITS - 1)
            begin
                dig_chars[j] = vtlf_pkg::CH_SPACE;
            end
            else
            begin
                lead         = 1'b0;
                dig_chars[j] = vtlf_pkg::CH_ZERO + {4'd0, d};
            end
        end
    end

    assign idx     = started_reg ? idx_reg : (head_desc.has_num ? '0 : FIRST_CONTENT);
    assign end_idx = TAB_POS + IDX_W'(clen);
    assign coff    = idx - FIRST_CONTENT;
    assign is_last = (idx == end_idx);
    assign load    = head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        if (idx < TAB_POS)
        begin
            sel_byte = dig_chars[idx[DIG_W-1:0]];
        end
        else if (idx == TAB_POS)
        begin
            sel_byte = vtlf_pkg::CH_TAB;
        end
        else
        begin
            sel_byte = cbytes[coff[1:0]];
        end
    end

    always_comb
    begin
        started_next   = started_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = sel_byte;
            out_last_next  = is_last;
            if (is_last)
            begin
                pop          = 1'b1;
                started_next = 1'b0;
            end
            else
            begin
                started_next = 1'b1;
                idx_next     = idx + IDX_W'(1);
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            started_reg   <= started_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

[sv/visible_text_line_formatter_core.sv]
// Text line formatter top level: config registers, front, queue, back.
// First output byte of an item: stored in the queue, then registered in the back part.
// Throughput: one output byte per cycle unless the sink stalls; an item of n
//   bytes holds the back part; the queue takes one item per cycle until full.
// Reset: asynchronous, active low; registers off, line counter zero.
module visible_text_line_formatter_core #(
    parameter int NUMBER_DIGITS = vtlf_pkg::NUMBER_DIGITS,
    parameter int FIFO_DEPTH    = vtlf_pkg::FIFO_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // data_byte
    input  logic                            s_axis_tuser,   // new_file
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // out_byte
    output logic                            m_axis_tlast,   // last_of_run
    input  logic                            cfg_we,
    input  logic [vtlf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vtlf_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int NUM_W  = 4 * NUMBER_DIGITS;
    localparam int DESC_W = $bits(vtlf_pkg::desc_t);
    localparam int Q_W    = DESC_W + NUM_W;

    vtlf_pkg::cfg_t  cfg_reg, cfg_next;
    vtlf_pkg::desc_t push_desc, head_desc;
    logic [NUM_W-1:0] push_num, head_num;
    logic             push, pop, full, empty;
    logic [Q_W-1:0]   q_in, q_out;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                vtlf_pkg::REG_NUMBER_MODE:      cfg_next.number_mode      = cfg_data;
                vtlf_pkg::REG_SQUEEZE_BLANK:    cfg_next.squeeze_blank    = cfg_data[0];
                vtlf_pkg::REG_SHOW_NONPRINTING: cfg_next.show_nonprinting = cfg_data[0];
                vtlf_pkg::REG_SHOW_LINE_ENDS:   cfg_next.show_line_ends   = cfg_data[0];
                vtlf_pkg::REG_SHOW_TAB_CHARS:   cfg_next.show_tab_chars   = cfg_data[0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    vtlf_front #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_data     (s_axis_tdata),
        .in_new_file (s_axis_tuser),
        .fifo_full   (full),
        .push        (push),
        .push_desc   (push_desc),
        .push_num    (push_num)
    );

    assign q_in = {push_desc, push_num};

    vtlf_fifo #(
        .WIDTH (Q_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .full      (full),
        .pop       (pop),
        .pop_data  (q_out),
        .empty     (empty)
    );

    assign head_desc = q_out[Q_W-1:NUM_W];
    assign head_num  = q_out[NUM_W-1:0];

    vtlf_back #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (!empty),
        .head_desc  (head_desc),
        .head_num   (head_num),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule

[sv/vtlf_checker.sv]
// Port-level checks of the text line formatter output stream, and its bind.
// Depends on vtlf_pkg and visible_text_line_formatter_core_defines.svh.
`include "visible_text_line_formatter_core_defines.svh"

module vtlf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // stalled output holds
    `VTLF_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed while stalled")

    // a raw newline only ever closes the run of a line-end item
    `VTLF_ASSERT_NOW(a_nl_last, clk, rst_n, m_axis_tvalid && m_axis_tdata == vtlf_pkg::CH_NL, m_axis_tlast, "newline byte not last of run")

    // bytes of one run come without gaps
    `VTLF_ASSERT_NEXT(a_run_gapless, clk, rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "gap inside a run")

endmodule

bind visible_text_line_formatter_core vtlf_checker u_vtlf_checker (.*);

[tb/vtlf_tb_pkg.sv]
// Scoreboard for the text line formatter testbench: predicts the decorated bytes per item.
// Depends on vtlf_pkg for register indexes, character codes and the digit count.
package vtlf_tb_pkg;

    import vtlf_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_char_t;

    class format_scoreboard;
        logic [1:0]                 number_mode;
        logic                       squeeze_blank;
        logic                       show_nonprinting;
        logic                       show_line_ends;
        logic                       show_tab_chars;
        logic                       at_line_start;
        logic                       previous_blank;
        logic [4*NUMBER_DIGITS-1:0] line_bcd;
        logic [7:0]                 staged[$];
        out_char_t                  expected_chars[$];
        int                         mismatches;
        int                         items_seen;
        int                         chars_checked;

        function new();
            number_mode      = NUM_OFF;
            squeeze_blank    = 1'b0;
            show_nonprinting = 1'b0;
            show_line_ends   = 1'b0;
            show_tab_chars   = 1'b0;
            at_line_start    = 1'b1;
            previous_blank   = 1'b0;
            line_bcd         = '0;
            mismatches       = 0;
            items_seen       = 0;
            chars_checked    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_NUMBER_MODE:      number_mode      = val;
                REG_SQUEEZE_BLANK:    squeeze_blank    = val[0];
                REG_SHOW_NONPRINTING: show_nonprinting = val[0];
                REG_SHOW_LINE_ENDS:   show_line_ends   = val[0];
                REG_SHOW_TAB_CHARS:   show_tab_chars   = val[0];
                default: ;
            endcase
        endfunction

        // bump the BCD counter (held at all nines), then stage the padded number and a tab
        function void stage_number();
            int         i;
            logic       all_nines;
            logic       carry;
            logic       leading;
            logic [3:0] d;
            all_nines = 1'b1;
            for (i = 0; i < NUMBER_DIGITS; i++)
            begin
                if (line_bcd[4*i +: 4] != 4'd9)
                    all_nines = 1'b0;
            end
            if (!all_nines)
            begin
                carry = 1'b1;
                for (i = 0; i < NUMBER_DIGITS; i++)
                begin
                    d = line_bcd[4*i +: 4];
                    if (carry && d == 4'd9)
                        line_bcd[4*i +: 4] = 4'd0;
                    else
                    begin
                        line_bcd[4*i +: 4] = d + {3'b0, carry};
                        carry = 1'b0;
                    end
                end
            end
            leading = 1'b1;
            for (i = NUMBER_DIGITS - 1; i >= 0; i--)
            begin
                d = line_bcd[4*i +: 4];
                if (leading && d == 4'd0 && i > 0)
                    staged.push_back(CH_SPACE);
                else
                begin
                    leading = 1'b0;
                    staged.push_back(CH_ZERO + {4'b0, d});
                end
            end
            staged.push_back(CH_TAB);
        endfunction

        function void stage_low7(logic [6:0] c);
            if (c < LOW_SPACE)
            begin
                staged.push_back(CH_CARET);
                staged.push_back({1'b0, c} + CTRL_OFFSET);
            end
            else if (c == LOW_DEL)
            begin
                staged.push_back(CH_CARET);
                staged.push_back(CH_QMARK);
            end
            else
                staged.push_back({1'b0, c});
        endfunction

        function void note_item(logic [7:0] c, logic new_file);
            out_char_t e;
            int        k;
            staged.delete();
            items_seen++;
            if (new_file)
            begin
                at_line_start  = 1'b1;
                previous_blank = 1'b0;
                line_bcd       = '0;
            end
            if (c == CH_NL)
            begin
                // repeated blank line: dropped, not numbered
                if (at_line_start && squeeze_blank && previous_blank)
                    return;
                if (at_line_start)
                begin
                    previous_blank = 1'b1;
                    if (number_mode == NUM_ALL)
                        stage_number();
                end
                if (show_line_ends)
                    staged.push_back(CH_DOLLAR);
                staged.push_back(CH_NL);
                at_line_start = 1'b1;
            end
            else
            begin
                if (at_line_start)
                begin
                    previous_blank = 1'b0;
                    if (number_mode != NUM_OFF)
                        stage_number();
                    at_line_start = 1'b0;
                end
                if (c == CH_TAB)
                begin
                    if (show_tab_chars)
                    begin
                        staged.push_back(CH_CARET);
                        staged.push_back(CH_I);
                    end
                    else
                        staged.push_back(CH_TAB);
                end
                else if (!show_nonprinting)
                    staged.push_back(c);
                else if (c[7])
                begin
                    staged.push_back(CH_M);
                    staged.push_back(CH_DASH);
                    stage_low7(c[6:0]);
                end
                else
                    stage_low7(c[6:0]);
            end
            for (k = 0; k < staged.size(); k++)
            begin
                e.out_byte    = staged[k];
                e.last_of_run = (k == staged.size() - 1);
                expected_chars.push_back(e);
            end
        endfunction

        function void check_result(logic [7:0] b, logic last);
            out_char_t e;
            chars_checked++;
            if (expected_chars.size() == 0)
            begin
                $error("out_byte: nothing expected, got %h (last_of_run %b)", b, last);
                mismatches++;
                return;
            end
            e = expected_chars.pop_front();
            if (b !== e.out_byte)
            begin
                $error("out_byte: expected %h, got %h", e.out_byte, b);
                mismatches++;
            end
            if (last !== e.last_of_run)
            begin
                $error("last_of_run: expected %b, got %b", e.last_of_run, last);
                mismatches++;
            end
        endfunction
    endclass

endpackage

[tb/tb_top.sv]
// Top-level testbench for visible_text_line_formatter_core: clock, reset, stream drivers.
// Depends on vtlf_pkg and vtlf_tb_pkg (scoreboard).
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import vtlf_pkg::*;
    import vtlf_tb_pkg::*;

    localparam int CYCLE_LIMIT     = 50_000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int COUNT_LINES     = 12;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 27;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = 8'h00;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    format_scoreboard sb;
    logic  src_idle_on = 1'b1;
    logic  snk_idle_on = 1'b1;
    int    stall_left  = 0;
    int    settings    = 0;
    longint cycles     = 0;

    always #1 clk = ~clk;

    visible_text_line_formatter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (snk_idle_on && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 5);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic nf);
        if (src_idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= nf;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_item(b, nf);
    endtask

    // squeezed lines leave nothing to wait for, hence the settle time
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic program_regs(input logic [1:0] mode, input logic [1:0] sq,
                                input logic [1:0] np, input logic [1:0] le,
                                input logic [1:0] tc);
        write_one(REG_NUMBER_MODE, mode);
        write_one(REG_SQUEEZE_BLANK, sq);
        write_one(REG_SHOW_NONPRINTING, np);
        write_one(REG_SHOW_LINE_ENDS, le);
        write_one(REG_SHOW_TAB_CHARS, tc);
        // unused index, must leave every register alone
        write_one(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                  CFG_DATA_W'($urandom()));
        cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 18)
            return CH_NL;
        else if (r < 22)
            return CH_TAB;
        else if (r < 60)
            return 8'($urandom_range(32, 126));
        else if (r < 75)
            return 8'($urandom_range(0, 31));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        int p;
        int i;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: bytes pass through untouched
        send_item(8'h41, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CH_TAB, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(CH_NL, 1'b0);
        wait_idle();

        // everything on: squeezing, caret and M- forms, line ends, mid-line new file
        program_regs(NUM_ALL, 2'd1, 2'd1, 2'd1, 2'd1);
        send_item(CH_NL, 1'b0);
        send_item(CH_NL, 1'b0);
        send_item(CH_NL, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h1F, 1'b0);
        send_item(CH_TAB, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h9F, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hA0, 1'b0);
        send_item(8'h20, 1'b0);
        send_item(8'h7E, 1'b0);
        send_item(CH_NL, 1'b0);
        send_item(8'h71, 1'b0);
        send_item(8'h72, 1'b1);
        send_item(CH_NL, 1'b1);
        wait_idle();

        // numbering mode three acts as non-blank only
        program_regs(2'd3, 2'd0, 2'd0, 2'd0, 2'd0);
        send_item(CH_NL, 1'b0);
        send_item(8'h78, 1'b0);
        send_item(CH_NL, 1'b0);
        wait_idle();

        // numbered blank lines, enough to carry into the tens digit
        program_regs(NUM_ALL, 2'd0, 2'd0, 2'd0, 2'd0);
        for (i = 0; i < COUNT_LINES; i++)
            send_item(CH_NL, i == 0);
        wait_idle();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                program_regs(2'd2, 2'd1, 2'd1, 2'd1, 2'd1);
            else if (p == 1)
                program_regs(2'd0, 2'd0, 2'd0, 2'd0, 2'd0);
            else
                program_regs(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                             2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                             2'($urandom_range(0, 3)));
            src_idle_on = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            snk_idle_on = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (i = 0; i < ITEMS_PER_PHASE; i++)
                send_item(pick_byte(), $urandom_range(0, 24) == 0);
            wait_idle();
        end

        if (sb.expected_chars.size() != 0)
        begin
            $error("out_byte: %0d expected bytes never arrived", sb.expected_chars.size());
            sb.mismatches++;
        end
        $display("Run covered %0d input items and %0d output bytes over %0d register settings,",
                 sb.items_seen, sb.chars_checked, settings);
        $display("including squeezing, caret forms, new-file restarts and a %0d-line count.",
                 COUNT_LINES);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
